FILE: src/tcrb_pkg.sv
package tcrb_pkg;

  localparam int DEFAULT_ROWS = 64;
  localparam int DEFAULT_COLS = 64;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_FW   = 6;
  localparam int COL_FW   = 7;
  localparam int ACT_W    = 3;

  localparam logic [OPCODE_W-1:0] OP_RECORD     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ       = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ_CLEAR = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_RESERVED   = 2'd3;

  localparam logic [ACT_W-1:0] ACT_IGNORED     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_NEWLINE     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_BACKSPACE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_WRAP_APPEND = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ        = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ_CLEAR  = 3'd6;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [ROW_FW-1:0]   read_row;
    logic [COL_FW-1:0]   read_col;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              row_was_dirty;
    logic [ROW_FW-1:0] current_row;
    logic [COL_FW-1:0] current_col;
    logic              ring_wrapped;
    logic [ACT_W-1:0]  action;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWLINE,
    ST_CHAR,
    ST_TERM,
    ST_READ
  } seq_state_t;

endpackage

FILE: src/tcrb_ram.sv
module tcrb_ram #(
  parameter int WIDTH = tcrb_pkg::CHAR_W,
  parameter int DEPTH = (tcrb_pkg::DEFAULT_COLS + 1) * tcrb_pkg::DEFAULT_ROWS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/text_console_ring_buffer.sv
// Character console text store: a ring of ROWS rows of up to COLS bytes, each row ended by a
// zero cell, held in one single-port-write synchronous memory of ROWS*(COLS+1) bytes. An item is
// taken when start is high and busy is low; its result shows on out_item for exactly one cycle
// with out_valid, the cycle after the item's last step, and must be taken then since the receiver
// cannot hold it off. Busy stays high while the item's steps run: none for an ignored byte or
// unused opcode, a terminator write for a backspace, a memory read for a read, character then
// terminator for a plain append, old line's end then new terminator for a line feed, and
// all three for a wrapping append; the write port stores one cell per cycle. Per-row valid bits
// stand in for the reset of the memory, so there is no clearing pass after reset.
module text_console_ring_buffer #(
  parameter int ROWS = tcrb_pkg::DEFAULT_ROWS,
  parameter int COLS = tcrb_pkg::DEFAULT_COLS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tcrb_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output tcrb_pkg::out_item_t out_item
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS + 1);
  localparam int DEPTH = ROWS * (COLS + 1);
  localparam int AW    = $clog2(DEPTH);

  localparam logic [AW-1:0] ROW_PITCH = AW'(COLS + 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] FULL_COL  = CW'(COLS);

  tcrb_pkg::seq_state_t state_r, state_nxt;

  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic            wrapped_r, wrapped_nxt;
  logic [ROWS-1:0] dirty_r, dirty_nxt;
  logic [ROWS-1:0] row_valid_r, row_valid_nxt;

  logic [tcrb_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [tcrb_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic                        rd_hit_r, rd_hit_nxt;
  logic                        rd_dirty_r, rd_dirty_nxt;

  logic                out_valid_r, finish;
  tcrb_pkg::out_item_t out_item_r, out_item_nxt;

  logic                        accept;
  logic                        is_lf, is_cr, is_bs, is_ctrl, col_full, rd_in_range;
  logic [RW-1:0]               rd_row;
  logic [CW-1:0]               rd_col;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tcrb_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

  assign busy   = (state_r != tcrb_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign is_lf    = (in_item.char_code == tcrb_pkg::CHAR_LF);
  assign is_cr    = (in_item.char_code == tcrb_pkg::CHAR_CR);
  assign is_bs    = (in_item.char_code == tcrb_pkg::CHAR_BS) ||
                    (in_item.char_code == tcrb_pkg::CHAR_DEL);
  assign is_ctrl  = (in_item.char_code < tcrb_pkg::CHAR_SPACE);
  assign col_full = (col_r == FULL_COL);

  assign rd_in_range = (int'(in_item.read_row) < ROWS) && (int'(in_item.read_col) <= COLS);
  assign rd_row      = RW'(in_item.read_row);
  assign rd_col      = CW'(in_item.read_col);

  assign ram_waddr = AW'(row_r) * ROW_PITCH + AW'(col_r);
  assign ram_raddr = AW'(rd_row) * ROW_PITCH + AW'(rd_col);

  tcrb_ram #(
    .WIDTH (tcrb_pkg::CHAR_W),
    .DEPTH (DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: every write step stores one cell at the current row and column.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcrb_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            tcrb_pkg::OP_RECORD: begin
              if (is_lf) begin
                state_nxt = tcrb_pkg::ST_NEWLINE;
              end else if (is_cr) begin
                state_nxt = tcrb_pkg::ST_IDLE;
              end else if (is_bs) begin
                state_nxt = (col_r != '0) ? tcrb_pkg::ST_TERM : tcrb_pkg::ST_IDLE;
              end else if (is_ctrl) begin
                state_nxt = tcrb_pkg::ST_IDLE;
              end else if (col_full) begin
                state_nxt = tcrb_pkg::ST_NEWLINE;
              end else begin
                state_nxt = tcrb_pkg::ST_CHAR;
              end
            end
            tcrb_pkg::OP_READ, tcrb_pkg::OP_READ_CLEAR: begin
              state_nxt = tcrb_pkg::ST_READ;
            end
            default: begin
              state_nxt = tcrb_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tcrb_pkg::ST_NEWLINE: begin
        state_nxt = (act_r == tcrb_pkg::ACT_WRAP_APPEND) ? tcrb_pkg::ST_CHAR
                                                         : tcrb_pkg::ST_TERM;
      end
      tcrb_pkg::ST_CHAR: begin
        state_nxt = tcrb_pkg::ST_TERM;
      end
      tcrb_pkg::ST_TERM, tcrb_pkg::ST_READ: begin
        state_nxt = tcrb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    wrapped_nxt   = wrapped_r;
    dirty_nxt     = dirty_r;
    row_valid_nxt = row_valid_r;
    ch_nxt        = ch_r;
    act_nxt       = act_r;
    rd_hit_nxt    = rd_hit_r;
    rd_dirty_nxt  = rd_dirty_r;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    finish        = 1'b0;

    case (state_r)
      tcrb_pkg::ST_IDLE: begin
        if (accept) begin
          ch_nxt       = in_item.char_code;
          rd_hit_nxt   = 1'b0;
          rd_dirty_nxt = 1'b0;
          case (in_item.opcode)
            tcrb_pkg::OP_RECORD: begin
              if (is_lf) begin
                act_nxt = tcrb_pkg::ACT_NEWLINE;
              end else if (is_cr) begin
                act_nxt = tcrb_pkg::ACT_IGNORED;
                finish  = 1'b1;
              end else if (is_bs) begin
                if (col_r != '0) begin
                  col_nxt          = col_r - 1'b1;
                  dirty_nxt[row_r] = 1'b1;
                  act_nxt          = tcrb_pkg::ACT_BACKSPACE;
                end else begin
                  act_nxt = tcrb_pkg::ACT_IGNORED;
                  finish  = 1'b1;
                end
              end else if (is_ctrl) begin
                act_nxt = tcrb_pkg::ACT_IGNORED;
                finish  = 1'b1;
              end else if (col_full) begin
                act_nxt = tcrb_pkg::ACT_WRAP_APPEND;
              end else begin
                act_nxt = tcrb_pkg::ACT_APPEND;
              end
            end
            tcrb_pkg::OP_READ, tcrb_pkg::OP_READ_CLEAR: begin
              act_nxt = (in_item.opcode == tcrb_pkg::OP_READ) ? tcrb_pkg::ACT_READ
                                                              : tcrb_pkg::ACT_READ_CLEAR;
              if (rd_in_range) begin
                ram_re       = 1'b1;
                // A row never written since reset reads as an empty line.
                rd_hit_nxt   = row_valid_r[rd_row];
                rd_dirty_nxt = dirty_r[rd_row];
                if (in_item.opcode == tcrb_pkg::OP_READ_CLEAR) begin
                  dirty_nxt[rd_row] = 1'b0;
                end
              end
            end
            default: begin
              act_nxt = tcrb_pkg::ACT_IGNORED;
              finish  = 1'b1;
            end
          endcase
        end
      end
      tcrb_pkg::ST_NEWLINE: begin
        // Terminate the old line, then move to an empty new one.
        ram_we             = 1'b1;
        row_valid_nxt[row_r] = 1'b1;
        row_nxt            = (row_r == LAST_ROW) ? '0 : row_r + 1'b1;
        col_nxt            = '0;
        dirty_nxt          = '1;
        if (row_r == LAST_ROW) begin
          wrapped_nxt = 1'b1;
        end
      end
      tcrb_pkg::ST_CHAR: begin
        ram_we               = 1'b1;
        ram_wdata            = ch_r;
        row_valid_nxt[row_r] = 1'b1;
        col_nxt              = col_r + 1'b1;
        dirty_nxt[row_r]     = 1'b1;
      end
      tcrb_pkg::ST_TERM: begin
        ram_we               = 1'b1;
        row_valid_nxt[row_r] = 1'b1;
        finish               = 1'b1;
      end
      tcrb_pkg::ST_READ: begin
        finish = 1'b1;
      end
      default: begin
        finish = 1'b0;
      end
    endcase

    out_item_nxt.cell_char     = ((state_r == tcrb_pkg::ST_READ) && rd_hit_r) ? ram_rdata : '0;
    out_item_nxt.row_was_dirty = (state_r == tcrb_pkg::ST_READ) && rd_dirty_r;
    out_item_nxt.current_row   = tcrb_pkg::ROW_FW'(row_nxt);
    out_item_nxt.current_col   = tcrb_pkg::COL_FW'(col_nxt);
    out_item_nxt.ring_wrapped  = wrapped_nxt;
    out_item_nxt.action        = act_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcrb_pkg::ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      wrapped_r   <= 1'b0;
      dirty_r     <= '1;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      wrapped_r   <= wrapped_nxt;
      dirty_r     <= dirty_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    act_r      <= act_nxt;
    rd_hit_r   <= rd_hit_nxt;
    rd_dirty_r <= rd_dirty_nxt;
    if (finish) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= FULL_COL)
    else $error("write column beyond the terminator slot");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) < ROWS)
    else $error("write row outside the ring");

  a_newline_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcrb_pkg::ST_NEWLINE) |=> (col_r == '0) && (&dirty_r))
    else $error("newline did not reset the column and mark all rows dirty");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept || busy))
    else $error("result strobe without an item in progress");

  a_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (busy && (state_r != tcrb_pkg::ST_READ)))
    else $error("text memory written outside a write step");

endmodule

FILE: verif/testbench.sv
module testbench;

  localparam int NROWS = tcrb_pkg::DEFAULT_ROWS;
  localparam int NCOLS = tcrb_pkg::DEFAULT_COLS;
  localparam int ITEM_TARGET = 750;
  localparam int STALL_LIMIT = 200;

  // Mirror of the console text store; expected results are queued in accept order.
  class text_store_model;
    logic [tcrb_pkg::CHAR_W-1:0] cells [NROWS][NCOLS+1];
    bit                          dirty [NROWS];
    int                          top_written [NROWS];
    int                          wrow;
    int                          wcol;
    bit                          wrapped;
    tcrb_pkg::out_item_t         expected_q [$];
    int                          errors;

    function new();
      foreach (dirty[r]) begin
        dirty[r] = 1'b1;
        top_written[r] = 0;
        cells[r][0] = '0;
      end
      wrow = 0;
      wcol = 0;
      wrapped = 1'b0;
      errors = 0;
    endfunction

    function void line_feed();
      cells[wrow][wcol] = '0;
      wrow = (wrow + 1) % NROWS;
      wcol = 0;
      cells[wrow][0] = '0;
      if (wrow == 0) wrapped = 1'b1;
      foreach (dirty[r]) dirty[r] = 1'b1;
    endfunction

    function tcrb_pkg::out_item_t console_step(tcrb_pkg::in_item_t it);
      tcrb_pkg::out_item_t r;
      r = '0;
      r.action = tcrb_pkg::ACT_IGNORED;
      case (it.opcode)
        tcrb_pkg::OP_RECORD: begin
          if (it.char_code == tcrb_pkg::CHAR_LF) begin
            line_feed();
            r.action = tcrb_pkg::ACT_NEWLINE;
          end else if (it.char_code == tcrb_pkg::CHAR_BS ||
                       it.char_code == tcrb_pkg::CHAR_DEL) begin
            if (wcol > 0) begin
              wcol--;
              cells[wrow][wcol] = '0;
              dirty[wrow] = 1'b1;
              r.action = tcrb_pkg::ACT_BACKSPACE;
            end
          end else if (it.char_code >= tcrb_pkg::CHAR_SPACE) begin
            r.action = tcrb_pkg::ACT_APPEND;
            if (wcol >= NCOLS) begin
              line_feed();
              r.action = tcrb_pkg::ACT_WRAP_APPEND;
            end
            cells[wrow][wcol] = it.char_code;
            wcol++;
            cells[wrow][wcol] = '0;
            if (wcol > top_written[wrow]) top_written[wrow] = wcol;
            dirty[wrow] = 1'b1;
          end
        end
        tcrb_pkg::OP_READ, tcrb_pkg::OP_READ_CLEAR: begin
          r.action = (it.opcode == tcrb_pkg::OP_READ) ? tcrb_pkg::ACT_READ
                                                      : tcrb_pkg::ACT_READ_CLEAR;
          if (int'(it.read_row) < NROWS && int'(it.read_col) <= NCOLS) begin
            r.cell_char = cells[it.read_row][it.read_col];
            r.row_was_dirty = dirty[it.read_row];
            if (it.opcode == tcrb_pkg::OP_READ_CLEAR) dirty[it.read_row] = 1'b0;
          end
        end
        default: ;
      endcase
      r.current_row = wrow[tcrb_pkg::ROW_FW-1:0];
      r.current_col = wcol[tcrb_pkg::COL_FW-1:0];
      r.ring_wrapped = wrapped;
      return r;
    endfunction

    function void note_item(tcrb_pkg::in_item_t it);
      expected_q.push_back(console_step(it));
    endfunction

    function void check_result(tcrb_pkg::out_item_t got);
      tcrb_pkg::out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.cell_char !== exp_r.cell_char) begin
        $error("cell_char: expected %0d, got %0d", exp_r.cell_char, got.cell_char);
        errors++;
      end
      if (got.row_was_dirty !== exp_r.row_was_dirty) begin
        $error("row_was_dirty: expected %0d, got %0d", exp_r.row_was_dirty, got.row_was_dirty);
        errors++;
      end
      if (got.current_row !== exp_r.current_row) begin
        $error("current_row: expected %0d, got %0d", exp_r.current_row, got.current_row);
        errors++;
      end
      if (got.current_col !== exp_r.current_col) begin
        $error("current_col: expected %0d, got %0d", exp_r.current_col, got.current_col);
        errors++;
      end
      if (got.ring_wrapped !== exp_r.ring_wrapped) begin
        $error("ring_wrapped: expected %0d, got %0d", exp_r.ring_wrapped, got.ring_wrapped);
        errors++;
      end
      if (got.action !== exp_r.action) begin
        $error("action: expected %0d, got %0d", exp_r.action, got.action);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  tcrb_pkg::in_item_t  in_item = '0;
  logic                busy;
  logic                out_valid;
  tcrb_pkg::out_item_t out_item;

  text_store_model sb;
  bit no_idle = 1'b0;
  int stall_cycles = 0;

  text_console_ring_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // A result and the next item can be taken at the same edge, so the result is checked first.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
    if (rst_n && start && !busy) sb.note_item(in_item);
    if (rst_n && (out_valid || (start && !busy))) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input tcrb_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic record(input logic [tcrb_pkg::CHAR_W-1:0] ch);
    tcrb_pkg::in_item_t it;
    it.opcode = tcrb_pkg::OP_RECORD;
    it.char_code = ch;
    it.read_row = tcrb_pkg::ROW_FW'($urandom);
    it.read_col = tcrb_pkg::COL_FW'($urandom_range(0, NCOLS));
    send(it);
  endtask

  task automatic read_cell(input logic [tcrb_pkg::OPCODE_W-1:0] op, input int row,
                           input int col);
    tcrb_pkg::in_item_t it;
    it.opcode = op;
    it.char_code = tcrb_pkg::CHAR_W'($urandom);
    it.read_row = row[tcrb_pkg::ROW_FW-1:0];
    it.read_col = col[tcrb_pkg::COL_FW-1:0];
    send(it);
  endtask

  function automatic logic [tcrb_pkg::CHAR_W-1:0] printable_byte();
    logic [tcrb_pkg::CHAR_W-1:0] c;
    do c = tcrb_pkg::CHAR_W'($urandom_range(32, 255)); while (c == tcrb_pkg::CHAR_DEL);
    return c;
  endfunction

  initial begin
    int counted;
    int sel;
    int len;
    int row;
    int col;
    tcrb_pkg::in_item_t odd;

    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, control and extreme bytes, deletes, line feed, reads, bad opcode.
    read_cell(tcrb_pkg::OP_READ, 0, 0);
    read_cell(tcrb_pkg::OP_READ_CLEAR, 5, 0);
    read_cell(tcrb_pkg::OP_READ, 5, 0);
    record(tcrb_pkg::CHAR_CR);
    record(8'h00);
    record(8'h1F);
    record(tcrb_pkg::CHAR_BS);
    record(tcrb_pkg::CHAR_DEL);
    record(tcrb_pkg::CHAR_SPACE);
    record(8'h7E);
    record(8'h80);
    record(8'hFF);
    record(tcrb_pkg::CHAR_BS);
    record(tcrb_pkg::CHAR_DEL);
    read_cell(tcrb_pkg::OP_READ, 0, 2);
    read_cell(tcrb_pkg::OP_READ, 0, 4);
    record(tcrb_pkg::CHAR_LF);
    read_cell(tcrb_pkg::OP_READ_CLEAR, 0, 1);
    read_cell(tcrb_pkg::OP_READ, 63, 0);
    read_cell(tcrb_pkg::OP_READ, 0, NCOLS + 1);
    read_cell(tcrb_pkg::OP_READ_CLEAR, 1, 127);
    odd.opcode = tcrb_pkg::OP_RESERVED;
    odd.char_code = 8'h41;
    odd.read_row = tcrb_pkg::ROW_FW'($urandom);
    odd.read_col = tcrb_pkg::COL_FW'($urandom_range(0, NCOLS));
    send(odd);
    record(8'h41);

    // Random: mostly text lines ended by a line feed, mixed with reads and noise.
    counted = 0;
    while (counted < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 3);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            record($urandom_range(0, 1) ? tcrb_pkg::CHAR_BS : tcrb_pkg::CHAR_DEL);
          end else begin
            record(printable_byte());
          end
        end
        record(tcrb_pkg::CHAR_LF);
        counted += len + 1;
      end else if (sel < 80) begin
        row = $urandom_range(0, 1) ? sb.wrow : $urandom_range(0, NROWS - 1);
        // Reads hit written cells or column 0 of an unwritten row; the rest are past the bound.
        if ($urandom_range(0, 29) == 0) col = $urandom_range(NCOLS + 1, 127);
        else col = $urandom_range(0, sb.top_written[row]);
        read_cell($urandom_range(0, 1) ? tcrb_pkg::OP_READ : tcrb_pkg::OP_READ_CLEAR, row, col);
        counted++;
      end else begin
        case ($urandom_range(0, 4))
          0: record(tcrb_pkg::CHAR_CR);
          1: record(tcrb_pkg::CHAR_W'($urandom_range(0, 31)));
          2: record(tcrb_pkg::CHAR_BS);
          3: record(tcrb_pkg::CHAR_DEL);
          default: begin
            odd.opcode = tcrb_pkg::OP_RESERVED;
            odd.char_code = tcrb_pkg::CHAR_W'($urandom);
            odd.read_row = tcrb_pkg::ROW_FW'($urandom);
            odd.read_col = tcrb_pkg::COL_FW'($urandom_range(0, NCOLS));
            send(odd);
          end
        endcase
        counted++;
      end
    end

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
src/tcrb_pkg.sv
src/tcrb_ram.sv
src/text_console_ring_buffer.sv
verif/testbench.sv
